// ----- rtl/core/rsw_pkg.sv -----
// shared types and constants for the reset supervisor with watchdog
package rsw_pkg;

    // link command codes
    typedef enum logic [2:0] {
        CMD_OTHER   = 3'd0,
        CMD_RESTART = 3'd1,
        CMD_LED     = 3'd2,
        CMD_WD_LOAD = 3'd3,
        CMD_WD_KICK = 3'd4
    } t_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LONG_PRESS  = 3'd0,
        CFG_RESET_PULSE = 3'd1,
        CFG_LINK_PAUSE  = 3'd2,
        CFG_FLASH_STEP  = 3'd3,
        CFG_WD_STEP     = 3'd4
    } t_cfg_idx;

    // magic arguments
    localparam logic [15:0] REBOOT_PLAIN  = 16'hA600;
    localparam logic [15:0] REBOOT_NORMAL = 16'hA601;
    localparam logic [15:0] REBOOT_LOADER = 16'hA602;
    localparam logic [15:0] KICK_MAGIC    = 16'h0042;

    // hold counter saturation
    localparam logic [7:0]  HOLD_MAX = 8'd255;

    // flash steps queued by the mode key and by commands
    localparam logic [2:0]  FLASH_NORMAL = 3'd2;
    localparam logic [2:0]  FLASH_LOADER = 3'd4;
    localparam logic [2:0]  FLASH_CMD    = 3'd2;

    // configuration reset values
    localparam logic [7:0]  LONG_PRESS_RST  = 8'd100;
    localparam logic [7:0]  RESET_PULSE_RST = 8'd20;
    localparam logic [7:0]  LINK_PAUSE_RST  = 8'd200;
    localparam logic [7:0]  FLASH_STEP_RST  = 8'd10;
    localparam logic [9:0]  WD_STEP_RST     = 10'd10;

endpackage

// ----- rtl/core/reset_supervisor_with_watchdog_unit.sv -----
// top level of the board reset supervisor with software watchdog
//
// Usage: one input transaction per 10 ms tick carries both key levels and an
// optional decoded link command with its 16-bit argument. Each tick yields
// exactly one result transaction with the reset line, boot pin, LED, link
// enable and command-taken flags as they stand after that tick.
// Both channels use valid/stall; a transaction moves on a clock edge with
// valid high and stall low. Configuration is a separate valid/ready write
// channel (ready is always high) that loads one of five timing registers by
// index; writes with an index outside the list are ignored.
// An input transaction passes through the input register, then the whole tick
// update runs in one pass of logic into the result register. Throughput is one
// tick per cycle while the receiver does not stall, set by that single state update.
// While the receiver stalls, the result register holds its transaction and
// the input register accepts one more tick; after that the input stalls.
// Synchronous reset puts the supervisor into its power-up state: reset line
// released, normal boot mode, LED off, watchdog disabled, default timings.
module reset_supervisor_with_watchdog_unit
    import rsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_left_key,
    input  logic        i_right_key,
    input  logic        i_command_valid,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_argument,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_reset_asserted,
    output logic        o_boot_loader_pin,
    output logic        o_led_on,
    output logic        o_link_enabled,
    output logic        o_command_taken,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    // configuration registers
    logic [7:0]  r_long_press;
    logic [7:0]  r_reset_pulse;
    logic [7:0]  r_link_pause;
    logic [7:0]  r_flash_step;
    logic [9:0]  r_wd_step;

    // input register
    logic        r_in_valid;
    logic        r_left;
    logic        r_right;
    logic        r_cvalid;
    logic [2:0]  r_cmd;
    logic [15:0] r_arg;

    // supervisor state
    logic [7:0]  r_left_hold,  n_left_hold;
    logic [7:0]  r_right_hold, n_right_hold;
    logic [7:0]  r_reset_hold, n_reset_hold;
    logic        r_mode_normal, n_mode_normal;
    logic        r_boot_pin,   n_boot_pin;
    logic        r_reset_line, n_reset_line;
    logic        r_led,        n_led;
    logic [7:0]  r_flash_phase, n_flash_phase;
    logic [2:0]  r_flash_left, n_flash_left;
    logic        r_flash_cmd,  n_flash_cmd;
    logic [7:0]  r_pause,      n_pause;
    logic [15:0] r_wd_reload,  n_wd_reload;
    logic [15:0] r_wd_count,   n_wd_count;
    logic        n_taken;

    // result register
    logic        r_out_valid;
    logic        r_out_reset;
    logic        r_out_boot;
    logic        r_out_led;
    logic        r_out_link;
    logic        r_out_taken;

    logic        w_adv;

    // stage handshake: advance when a tick is held and the result slot frees
    assign w_adv       = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !w_adv;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= LONG_PRESS_RST;
            r_reset_pulse <= RESET_PULSE_RST;
            r_link_pause  <= LINK_PAUSE_RST;
            r_flash_step  <= FLASH_STEP_RST;
            r_wd_step     <= WD_STEP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_PRESS:  r_long_press  <= i_cfg_data[7:0];
                CFG_RESET_PULSE: r_reset_pulse <= i_cfg_data[7:0];
                CFG_LINK_PAUSE:  r_link_pause  <= i_cfg_data[7:0];
                CFG_FLASH_STEP:  r_flash_step  <= i_cfg_data[7:0];
                CFG_WD_STEP:     r_wd_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_left   <= i_left_key;
            r_right  <= i_right_key;
            r_cvalid <= i_command_valid;
            r_cmd    <= i_command;
            r_arg    <= i_argument;
        end
    end

    // one tick of the supervisor: keys, link pause, command, watchdog, flash
    always_comb begin
        n_left_hold   = r_left_hold;
        n_right_hold  = r_right_hold;
        n_reset_hold  = r_reset_hold;
        n_mode_normal = r_mode_normal;
        n_boot_pin    = r_boot_pin;
        n_reset_line  = r_reset_line;
        n_led         = r_led;
        n_flash_phase = r_flash_phase;
        n_flash_left  = r_flash_left;
        n_flash_cmd   = r_flash_cmd;
        n_pause       = r_pause;
        n_wd_reload   = r_wd_reload;
        n_wd_count    = r_wd_count;
        n_taken       = 1'b0;

        // reset key
        if (r_left) begin
            if (n_left_hold != HOLD_MAX) begin
                n_left_hold = n_left_hold + 8'd1;
            end
            if (n_left_hold == r_long_press) begin
                n_led        = 1'b1;
                n_boot_pin   = !r_mode_normal;
                n_pause      = r_link_pause;
                n_reset_line = 1'b1;
                n_reset_hold = r_reset_pulse;
            end
        end else begin
            n_left_hold = 8'd0;
            if (n_reset_hold != 8'd0) begin
                n_reset_hold = n_reset_hold - 8'd1;
                if (n_reset_hold == 8'd0) begin
                    n_reset_line = 1'b0;
                    n_led        = 1'b0;
                end
            end
        end

        // boot mode key
        if (r_right) begin
            if (n_right_hold != HOLD_MAX) begin
                n_right_hold = n_right_hold + 8'd1;
            end
            if (n_right_hold == r_long_press) begin
                n_mode_normal = !r_mode_normal;
                if (n_mode_normal) begin
                    n_boot_pin   = 1'b0;
                    n_flash_left = FLASH_NORMAL;
                end else begin
                    n_boot_pin   = 1'b1;
                    n_flash_left = FLASH_LOADER;
                end
            end
        end else begin
            n_right_hold = 8'd0;
        end

        // link pause countdown
        if (n_pause != 8'd0) begin
            n_pause = n_pause - 8'd1;
        end

        // link command
        if (n_pause == 8'd0 && r_cvalid) begin
            n_taken = 1'b1;
            if (r_flash_cmd) begin
                n_flash_left = FLASH_CMD;
            end
            case (t_cmd'(r_cmd))
                CMD_RESTART: begin
                    if (r_arg == REBOOT_PLAIN) begin
                        n_reset_line = 1'b1;
                        n_reset_hold = r_reset_pulse;
                    end else if (r_arg == REBOOT_NORMAL) begin
                        n_boot_pin   = 1'b0;
                        n_reset_line = 1'b1;
                        n_reset_hold = r_reset_pulse;
                    end else if (r_arg == REBOOT_LOADER) begin
                        n_boot_pin   = 1'b1;
                        n_reset_line = 1'b1;
                        n_reset_hold = r_reset_pulse;
                    end
                end
                CMD_LED: begin
                    n_flash_cmd = r_arg[0];
                end
                CMD_WD_LOAD: begin
                    n_wd_reload = r_arg;
                    n_wd_count  = r_arg;
                end
                CMD_WD_KICK: begin
                    if (r_arg == KICK_MAGIC) begin
                        n_wd_count = r_wd_reload;
                    end
                end
                default: ;
            endcase
        end

        // watchdog countdown, reset pulse on expiry
        if (n_wd_count != 16'd0) begin
            if (n_wd_count > {6'd0, r_wd_step}) begin
                n_wd_count = n_wd_count - {6'd0, r_wd_step};
            end else begin
                n_wd_count   = 16'd0;
                n_reset_line = 1'b1;
                n_reset_hold = r_reset_pulse;
            end
        end

        // led flash sequencer
        if (n_flash_left != 3'd0) begin
            n_flash_phase = n_flash_phase + 8'd1;
            if (n_flash_phase == r_flash_step) begin
                n_flash_left  = n_flash_left - 3'd1;
                n_flash_phase = 8'd0;
                n_led         = n_flash_left[0];
            end
        end
    end

    // supervisor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_hold   <= 8'd0;
            r_right_hold  <= 8'd0;
            r_reset_hold  <= 8'd0;
            r_mode_normal <= 1'b1;
            r_boot_pin    <= 1'b0;
            r_reset_line  <= 1'b0;
            r_led         <= 1'b0;
            r_flash_phase <= 8'd0;
            r_flash_left  <= 3'd0;
            r_flash_cmd   <= 1'b1;
            r_pause       <= 8'd0;
            r_wd_reload   <= 16'd0;
            r_wd_count    <= 16'd0;
        end else if (w_adv) begin
            r_left_hold   <= n_left_hold;
            r_right_hold  <= n_right_hold;
            r_reset_hold  <= n_reset_hold;
            r_mode_normal <= n_mode_normal;
            r_boot_pin    <= n_boot_pin;
            r_reset_line  <= n_reset_line;
            r_led         <= n_led;
            r_flash_phase <= n_flash_phase;
            r_flash_left  <= n_flash_left;
            r_flash_cmd   <= n_flash_cmd;
            r_pause       <= n_pause;
            r_wd_reload   <= n_wd_reload;
            r_wd_count    <= n_wd_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_reset <= n_reset_line;
            r_out_boot  <= n_boot_pin;
            r_out_led   <= n_led;
            r_out_link  <= (n_pause == 8'd0);
            r_out_taken <= n_taken;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_reset_asserted  = r_out_reset;
    assign o_boot_loader_pin = r_out_boot;
    assign o_led_on          = r_out_led;
    assign o_link_enabled    = r_out_link;
    assign o_command_taken   = r_out_taken;

endmodule

// ----- rtl/core/rsw_checker.sv -----
// port-level checker for the reset supervisor, with its bind
module rsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_reset_asserted,
    input logic        o_boot_loader_pin,
    input logic        o_led_on,
    input logic        o_link_enabled,
    input logic        o_command_taken
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reset_asserted)
            && $stable(o_boot_loader_pin) && $stable(o_led_on)
            && $stable(o_link_enabled) && $stable(o_command_taken))
        else $error("stalled result changed");

    // no command is taken while the link is paused
    a_pause_blocks_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_link_enabled |-> !o_command_taken)
        else $error("command taken during link pause");

    // no result comes straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind reset_supervisor_with_watchdog_unit rsw_checker u_rsw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_reset_asserted  (o_reset_asserted),
    .o_boot_loader_pin (o_boot_loader_pin),
    .o_led_on          (o_led_on),
    .o_link_enabled    (o_link_enabled),
    .o_command_taken   (o_command_taken)
);
